// ===== hdl/scv_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 chain link verifier package
// Shared types, round constants and the SHA-256 round and schedule functions.
// ----------------------------------------------------------------------------
package scv_pkg;

  localparam int unsigned NumRounds = 64;
  localparam int unsigned RndIdxW   = 6;

  typedef struct packed {
    logic [63:0] prev_word0;
    logic [63:0] prev_word1;
    logic [63:0] prev_word2;
    logic [63:0] prev_word3;
    logic [63:0] curr_word0;
    logic [63:0] curr_word1;
    logic [63:0] curr_word2;
    logic [63:0] curr_word3;
    logic        last_in_batch;
  } in_item_t;

  typedef struct packed {
    logic        link_ok;
    logic [31:0] pairs_checked;
    logic [31:0] mismatches_seen;
    logic [31:0] batches_done;
  } out_item_t;

  // Working variables a..h, a in the top word
  typedef logic [7:0][31:0] hash_state_t;
  // Message schedule window, w[i] at index i (lowest is the oldest)
  typedef logic [15:0][31:0] sched_win_t;

  // Payload that rides along with the hash
  typedef struct packed {
    logic [255:0] curr;
    logic         last;
  } side_t;

  // Result of the hash unit toward the counter stage
  typedef struct packed {
    logic ok;
    logic last;
  } cmp_t;

  localparam hash_state_t InitH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] round_k(input logic [RndIdxW-1:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One compression round with the schedule word for this round
  function automatic hash_state_t sha_round(input hash_state_t s, input logic [31:0] k,
                                            input logic [31:0] w);
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] big0, big1, ch, maj, t1, t2;
    hash_state_t r;
    a = s[7]; b = s[6]; c = s[5]; d = s[4];
    e = s[3]; f = s[2]; g = s[1]; h = s[0];
    big1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
    ch   = (e & f) ^ (~e & g);
    t1   = h + big1 + ch + k + w;
    big0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
    maj  = (a & b) ^ (a & c) ^ (b & c);
    t2   = big0 + maj;
    r = {t1 + t2, a, b, c, d + t1, e, f, g};
    return r;
  endfunction

  // Shift the schedule window by one, appending the next word
  function automatic sched_win_t sched_step(input sched_win_t win);
    logic [31:0] s0, s1, nw;
    sched_win_t r;
    s0 = rotr(win[1], 7) ^ rotr(win[1], 18) ^ (win[1] >> 3);
    s1 = rotr(win[14], 17) ^ rotr(win[14], 19) ^ (win[14] >> 10);
    nw = win[0] + s0 + win[9] + s1;
    r = {nw, win[15:1]};
    return r;
  endfunction

endpackage

// ===== hdl/sha256_chain_link_verifier.sv =====
// ----------------------------------------------------------------------------
// SHA-256 chain link verifier
// Hashes the previous hash, compares to the current hash, keeps counters.
// ----------------------------------------------------------------------------
// The input, round stage, compare and output registers lie between an accepted
// input and output valid; the 64 unrolled rounds set depth. One transaction
// per cycle unless a stalled output result freezes the whole pipeline.
// Reset clears all valid bits and the three counters to zero.
module sha256_chain_link_verifier (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  scv_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output scv_pkg::out_item_t out_data
);

  logic               adv;
  logic               hv;
  scv_pkg::cmp_t      cmp;
  logic               ov_r;
  scv_pkg::out_item_t od_r;
  logic [31:0]        pair_nxt, mis_nxt, bat_nxt;

  // Move the pipe unless the output holds an untaken result
  assign adv      = !(ov_r && out_stall);
  assign in_stall = !adv;

  scv_hash_pipe u_pipe (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .v_in    (in_valid),
    .item    (in_data),
    .v_out   (hv),
    .cmp_out (cmp)
  );

  // Saturating counter updates
  always_comb begin
    pair_nxt = (od_r.pairs_checked == '1) ? od_r.pairs_checked
                                           : od_r.pairs_checked + 32'd1;
    mis_nxt  = od_r.mismatches_seen;
    if (!cmp.ok && od_r.mismatches_seen != '1) begin
      mis_nxt = od_r.mismatches_seen + 32'd1;
    end
    bat_nxt  = od_r.batches_done;
    if (cmp.last && od_r.batches_done != '1) begin
      bat_nxt = od_r.batches_done + 32'd1;
    end
  end

  // Counters live in the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      od_r <= '0;
    end else if (adv) begin
      ov_r <= hv;
      if (hv) begin
        od_r <= '{link_ok: cmp.ok, pairs_checked: pair_nxt,
                  mismatches_seen: mis_nxt, batches_done: bat_nxt};
      end
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

// ===== hdl/scv_round_stage.sv =====
// ----------------------------------------------------------------------------
// SHA-256 round stage
// One registered compression round plus one schedule step, with valid bit.
// ----------------------------------------------------------------------------
module scv_round_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic [5:0]                  rnd,
  input  logic                        v_in,
  input  scv_pkg::hash_state_t        st_in,
  input  scv_pkg::sched_win_t         win_in,
  input  scv_pkg::side_t              side_in,
  output logic                        v_out,
  output scv_pkg::hash_state_t        st_out,
  output scv_pkg::sched_win_t         win_out,
  output scv_pkg::side_t              side_out
);

  logic                 v_r;
  scv_pkg::hash_state_t st_r;
  scv_pkg::sched_win_t  win_r;
  scv_pkg::side_t       side_r;

  // Advance valid when the pipe moves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= v_in;
    end
  end

  // Compute round and schedule step on advance
  always_ff @(posedge clk) begin
    if (adv) begin
      st_r   <= scv_pkg::sha_round(st_in, scv_pkg::round_k(rnd), win_in[0]);
      win_r  <= scv_pkg::sched_step(win_in);
      side_r <= side_in;
    end
  end

  assign v_out    = v_r;
  assign st_out   = st_r;
  assign win_out  = win_r;
  assign side_out = side_r;

endmodule

// ===== hdl/scv_hash_pipe.sv =====
// ----------------------------------------------------------------------------
// SHA-256 hash pipeline
// Input register, 64 round stages, then digest add and compare stage.
// ----------------------------------------------------------------------------
module scv_hash_pipe (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 v_in,
  input  scv_pkg::in_item_t    item,
  output logic                 v_out,
  output scv_pkg::cmp_t        cmp_out
);

  logic                 v_s   [scv_pkg::NumRounds+1];
  scv_pkg::hash_state_t st_s  [scv_pkg::NumRounds+1];
  scv_pkg::sched_win_t  win_s [scv_pkg::NumRounds+1];
  scv_pkg::side_t       side_s[scv_pkg::NumRounds+1];

  logic                 v0_r;
  scv_pkg::sched_win_t  win0_r;
  scv_pkg::side_t       side0_r;
  logic                 vc_r;
  scv_pkg::cmp_t        cmp_r;
  scv_pkg::hash_state_t dig;

  // Register the transaction and build the padded block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      win0_r <= {32'd256, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h80000000,
                 item.prev_word3[31:0], item.prev_word3[63:32],
                 item.prev_word2[31:0], item.prev_word2[63:32],
                 item.prev_word1[31:0], item.prev_word1[63:32],
                 item.prev_word0[31:0], item.prev_word0[63:32]};
      side0_r <= '{curr: {item.curr_word0, item.curr_word1, item.curr_word2,
                          item.curr_word3}, last: item.last_in_batch};
    end
  end

  assign v_s[0]    = v0_r;
  assign st_s[0]   = scv_pkg::InitH;
  assign win_s[0]  = win0_r;
  assign side_s[0] = side0_r;

  // Unrolled rounds
  for (genvar i = 0; i < scv_pkg::NumRounds; i++) begin : g_rnd
    scv_round_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .rnd      (scv_pkg::RndIdxW'(i)),
      .v_in     (v_s[i]),
      .st_in    (st_s[i]),
      .win_in   (win_s[i]),
      .side_in  (side_s[i]),
      .v_out    (v_s[i+1]),
      .st_out   (st_s[i+1]),
      .win_out  (win_s[i+1]),
      .side_out (side_s[i+1])
    );
  end

  // Add initial hash and compare
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      dig[j] = st_s[scv_pkg::NumRounds][j] + scv_pkg::InitH[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (adv) begin
      vc_r <= v_s[scv_pkg::NumRounds];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmp_r.ok   <= (dig == side_s[scv_pkg::NumRounds].curr);
      cmp_r.last <= side_s[scv_pkg::NumRounds].last;
    end
  end

  assign v_out   = vc_r;
  assign cmp_out = cmp_r;

endmodule

// ===== verif/sha256_chain_link_verifier_tb.sv =====
// ----------------------------------------------------------------------------
// SHA-256 chain link verifier testbench
// Drives hash pairs through the valid/stall channel under random idling on
// both sides and checks each result against an in-bench SHA-256 predictor.
// ----------------------------------------------------------------------------
module sha256_chain_link_verifier_tb;

  localparam int unsigned Latency = 67;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  scv_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  scv_pkg::out_item_t out_data;

  scv_pkg::in_item_t  pending_pairs[$];
  scv_pkg::out_item_t expected_links[$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit        in_taken;
  bit        failed;

  // Predictor state
  logic [31:0] pair_cnt;
  logic [31:0] miss_cnt;
  logic [31:0] batch_cnt;

  localparam logic [31:0] KTab[64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  localparam logic [31:0] HInit[8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // SHA-256 of one 32-byte message, padded to a single block
  function automatic logic [255:0] hash_prev(logic [255:0] msg);
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] s0, s1, t1, t2;
    logic [255:0] dig;
    for (int i = 0; i < 8; i++) w[i] = msg[255 - 32*i -: 32];
    w[8] = 32'h80000000;
    for (int i = 9; i < 15; i++) w[i] = '0;
    w[15] = 32'd256;
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = HInit[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTab[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) dig[255 - 32*i -: 32] = HInit[i] + v[i];
    return dig;
  endfunction

  function automatic logic [31:0] sat_up(logic [31:0] c);
    return (c == 32'hFFFFFFFF) ? c : c + 32'd1;
  endfunction

  // Advance the counters and build the expected result for one pair
  function automatic scv_pkg::out_item_t predict_link(scv_pkg::in_item_t p);
    scv_pkg::out_item_t r;
    logic ok;
    ok = hash_prev({p.prev_word0, p.prev_word1, p.prev_word2, p.prev_word3}) ==
         {p.curr_word0, p.curr_word1, p.curr_word2, p.curr_word3};
    pair_cnt = sat_up(pair_cnt);
    if (!ok) miss_cnt = sat_up(miss_cnt);
    if (p.last_in_batch) batch_cnt = sat_up(batch_cnt);
    r.link_ok = ok;
    r.pairs_checked = pair_cnt;
    r.mismatches_seen = miss_cnt;
    r.batches_done = batch_cnt;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    logic [63:0] x;
    case ($urandom_range(0, 5))
      0: x = '0;
      1: x = '1;
      default: x = {$urandom(), $urandom()};
    endcase
    return x;
  endfunction

  // Random pair; a good one carries the correct current hash, one in four with a bit flipped
  function automatic scv_pkg::in_item_t rand_pair(bit good);
    scv_pkg::in_item_t p;
    logic [255:0] d;
    p.prev_word0 = rand64(); p.prev_word1 = rand64();
    p.prev_word2 = rand64(); p.prev_word3 = rand64();
    d = hash_prev({p.prev_word0, p.prev_word1, p.prev_word2, p.prev_word3});
    if (good) begin
      {p.curr_word0, p.curr_word1, p.curr_word2, p.curr_word3} = d;
      if ($urandom_range(0, 3) == 0) d[$urandom_range(0, 255)] ^= 1'b1;
      else d = {p.curr_word0, p.curr_word1, p.curr_word2, p.curr_word3};
      {p.curr_word0, p.curr_word1, p.curr_word2, p.curr_word3} = d;
    end else begin
      p.curr_word0 = rand64(); p.curr_word1 = rand64();
      p.curr_word2 = rand64(); p.curr_word3 = rand64();
    end
    p.last_in_batch = ($urandom_range(0, 4) == 0);
    return p;
  endfunction

  function automatic scv_pkg::in_item_t fill_pair(logic [63:0] pv, bit good, bit last);
    scv_pkg::in_item_t p;
    p.prev_word0 = pv; p.prev_word1 = pv; p.prev_word2 = pv; p.prev_word3 = pv;
    {p.curr_word0, p.curr_word1, p.curr_word2, p.curr_word3} =
      good ? hash_prev({4{pv}}) : {4{~pv}};
    p.last_in_batch = last;
    return p;
  endfunction

  sha256_chain_link_verifier dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Driver: hold a transaction not yet taken, otherwise advance or idle
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      in_data  <= pending_pairs.pop_front();
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Predict on input acceptance, check on output acceptance
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) expected_links.push_back(predict_link(in_data));
    if (rst_n && out_valid && !out_stall) begin
      if (expected_links.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        failed = 1'b1;
      end else begin
        scv_pkg::out_item_t e;
        e = expected_links.pop_front();
        if (e.link_ok != out_data.link_ok)
          $display("%0t: link_ok exp %0d got %0d", $time, e.link_ok, out_data.link_ok);
        if (e.pairs_checked != out_data.pairs_checked)
          $display("%0t: pairs_checked exp %0d got %0d", $time, e.pairs_checked,
                   out_data.pairs_checked);
        if (e.mismatches_seen != out_data.mismatches_seen)
          $display("%0t: mismatches_seen exp %0d got %0d", $time, e.mismatches_seen,
                   out_data.mismatches_seen);
        if (e.batches_done != out_data.batches_done)
          $display("%0t: batches_done exp %0d got %0d", $time, e.batches_done,
                   out_data.batches_done);
        if (e != out_data) failed = 1'b1;
      end
    end
  end

  // Stimulus
  initial begin
    rst_n = 1'b0; in_valid = 1'b0; out_stall = 1'b0; in_data = '0;
    pair_cnt = '0; miss_cnt = '0; batch_cnt = '0;
    failed = 1'b0; in_taken = 1'b0;
    send_idle_pct = 16; recv_idle_pct = 61;
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    // Directed: all-zero and all-one fields, match/mismatch, batch marks
    pending_pairs.push_back(fill_pair('0, 1'b1, 1'b0));
    pending_pairs.push_back(fill_pair('0, 1'b0, 1'b1));
    pending_pairs.push_back(fill_pair('1, 1'b1, 1'b1));
    pending_pairs.push_back(fill_pair('1, 1'b0, 1'b0));
    begin
      scv_pkg::in_item_t p;
      p = '1;
      pending_pairs.push_back(p);
      p = '0;
      pending_pairs.push_back(p);
    end
    for (int i = 0; i < 10; i++) pending_pairs.push_back(rand_pair(i % 2));
    // Random, three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      for (int i = 0; i < 200; i++) pending_pairs.push_back(rand_pair($urandom_range(0, 1)));
      wait (pending_pairs.size() == 0);
      if (ph == 0) begin
        send_idle_pct = 61; recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
    end
    @(posedge clk);
    wait (!in_valid);
    wait (expected_links.size() == 0);
    repeat (Latency + 10) @(posedge clk);
    if (!failed && expected_links.size() == 0)
      $display("sha256_chain_link_verifier regression: pass");
    else
      $display("sha256_chain_link_verifier regression: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("sha256_chain_link_verifier regression: fail");
    $finish;
  end

endmodule
